// ===== rtl/trb_pkg.sv =====
// trb_pkg: shared codes and control structs for the trace ring buffer.
// Used by trb_ctrl, trb_datapath and trace_ring_buffer_top. No dependencies.
package trb_pkg;

    // Item mode codes
    localparam logic [2:0] MODE_INSERT = 3'd0;
    localparam logic [2:0] MODE_LOCK   = 3'd1;
    localparam logic [2:0] MODE_UNLOCK = 3'd2;
    localparam logic [2:0] MODE_READ   = 3'd3;
    localparam logic [2:0] MODE_CLEAR  = 3'd4;

    // Configuration register indexes
    localparam int CFG_IDX_W = 2;
    localparam logic [CFG_IDX_W-1:0] CFG_WRAP_ENABLE = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_SIZE_LOG2   = 2'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_OWNER_MASK  = 2'd2;
    localparam int CFG_DATA_W = 32;

    // Register reset values
    localparam logic [3:0]  SIZE_LOG2_RESET  = 4'd10;
    localparam logic [31:0] OWNER_MASK_RESET = 32'hFFFF_FFFF;
    localparam logic [3:0]  SIZE_LOG2_MIN    = 4'd4;

    // Saturation limits
    localparam logic [7:0]  LOCK_MAX    = 8'hFF;
    localparam logic [15:0] BLOCKED_MAX = 16'hFFFF;

    // Controller to datapath
    typedef struct packed {
        logic accept;     // input beat taken this cycle
        logic scan_next;  // scan miss, step to the next slot
        logic scan_done;  // scan ends, push the read result
        logic clr_step;   // clearing pass writes one slot
    } trb_cmd_t;

    // Datapath to controller
    typedef struct packed {
        logic skid_full;  // result skid holds a beat
        logic rd_scan;    // input item is a read that walks the store
        logic is_clear;   // input item is a clear
        logic scan_hit;   // slot under scan holds a selected record
        logic scan_last;  // slot under scan is the newest one
        logic clr_last;   // clearing pass is at the last slot
    } trb_status_t;

endpackage

// ===== rtl/trace_ring_buffer_top.sv =====
// trace_ring_buffer_top: top level of the trace ring buffer.
// Depends on trb_pkg, trb_ctrl and trb_datapath.
//
// Usage:
//   Input channel (in_valid / in_stall) carries one item per beat: mode,
//   rec_data, rec_owner, restart. Output channel (out_valid / out_stall)
//   returns exactly one result beat per item, in order.
//   Configuration writes (cfg_we, cfg_index, cfg_data) are registered; the
//   user makes them only while the block is idle, which it does not enforce.
//   Insert, lock, unlock, clear and reads that find nothing to walk register
//   their result into the output register, or into the skid while the
//   output is held. A read that walks the store loads its start slot into
//   the registered store word, then checks one slot per cycle through the
//   single store read port until a selected record or the newest slot.
//   Throughput: one non-walking item per cycle while in_stall is low.
//   Clear and reset: a clearing pass writes every slot of the store, one per
//   cycle, 2**LOG_DEPTH slots (1024 by default); in_stall is high meanwhile.
//   Stall: a result waiting on out_stall sits in the output register; one
//   more item may be taken into the skid, after which in_stall rises.
module trace_ring_buffer_top
    import trb_pkg::*;
#(
    parameter int LOG_DEPTH  = 10,
    parameter int DATA_WIDTH = 32,
    parameter int OWNER_BITS = 5
)
(
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  cfg_we,
    input  logic [CFG_IDX_W-1:0]  cfg_index,
    input  logic [CFG_DATA_W-1:0] cfg_data,
    input  logic                  in_valid,
    output logic                  in_stall,
    input  logic [2:0]            mode,
    input  logic [DATA_WIDTH-1:0] rec_data,
    input  logic [OWNER_BITS-1:0] rec_owner,
    input  logic                  restart,
    output logic                  out_valid,
    input  logic                  out_stall,
    output logic                  ok,
    output logic [LOG_DEPTH-1:0]  slot,
    output logic [DATA_WIDTH-1:0] out_data,
    output logic [OWNER_BITS-1:0] out_owner,
    output logic                  found,
    output logic                  overflowed,
    output logic [LOG_DEPTH:0]    entry_count,
    output logic [15:0]           blocked_total,
    output logic                  locked
);

    trb_cmd_t    cmd;
    trb_status_t st;

    trb_ctrl u_ctrl (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (in_valid),
        .in_stall (in_stall),
        .st       (st),
        .cmd      (cmd)
    );

    trb_datapath #(
        .LOG_DEPTH  (LOG_DEPTH),
        .DATA_WIDTH (DATA_WIDTH),
        .OWNER_BITS (OWNER_BITS)
    ) u_datapath (
        .clk           (clk),
        .rst_n         (rst_n),
        .cfg_we        (cfg_we),
        .cfg_index     (cfg_index),
        .cfg_data      (cfg_data),
        .mode          (mode),
        .rec_data      (rec_data),
        .rec_owner     (rec_owner),
        .restart       (restart),
        .out_valid     (out_valid),
        .out_stall     (out_stall),
        .ok            (ok),
        .slot          (slot),
        .out_data      (out_data),
        .out_owner     (out_owner),
        .found         (found),
        .overflowed    (overflowed),
        .entry_count   (entry_count),
        .blocked_total (blocked_total),
        .locked        (locked),
        .cmd           (cmd),
        .st            (st)
    );

endmodule

// ===== rtl/trb_ctrl.sv =====
// trb_ctrl: controller state machine for the trace ring buffer.
// Depends on trb_pkg; drives trb_datapath through trb_cmd_t.
module trb_ctrl
    import trb_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        in_valid,
    output logic        in_stall,
    input  trb_status_t st,
    output trb_cmd_t    cmd
);

    localparam logic [1:0] ST_IDLE  = 2'd0;
    localparam logic [1:0] ST_SCAN  = 2'd1;
    localparam logic [1:0] ST_CLEAR = 2'd2;

    logic [1:0] state_reg;
    logic [1:0] state_next;

    // Next state and commands
    always_comb
    begin
        state_next = state_reg;
        cmd        = '0;
        in_stall   = 1'b1;
        unique case (state_reg)
            ST_IDLE:
            begin
                in_stall   = st.skid_full;
                cmd.accept = in_valid && !st.skid_full;
                if (cmd.accept && st.rd_scan)
                begin
                    state_next = ST_SCAN;
                end
                else if (cmd.accept && st.is_clear)
                begin
                    state_next = ST_CLEAR;
                end
            end
            ST_SCAN:
            begin
                if (st.scan_hit || st.scan_last)
                begin
                    cmd.scan_done = 1'b1;
                    state_next    = ST_IDLE;
                end
                else
                begin
                    cmd.scan_next = 1'b1;
                end
            end
            ST_CLEAR:
            begin
                cmd.clr_step = 1'b1;
                if (st.clr_last)
                begin
                    state_next = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    // State register; reset starts the clearing pass
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_CLEAR;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    // At most one action per cycle
    a_cmd_onehot: assert property (@(posedge clk) disable iff (!rst_n)
        $onehot0({cmd.accept, cmd.scan_next, cmd.scan_done, cmd.clr_step}))
        else $error("trb_ctrl: more than one command active");

    // Clearing pass ends back in idle
    a_clear_exit: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ST_CLEAR && st.clr_last) |=> (state_reg == ST_IDLE))
        else $error("trb_ctrl: clearing pass did not return to idle");

    // Input is held off outside idle
    a_busy_stall: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg != ST_IDLE) |-> in_stall)
        else $error("trb_ctrl: input not stalled while busy");

endmodule

// ===== rtl/trb_datapath.sv =====
// trb_datapath: trace store memory, pointers, counters and result skid.
// Depends on trb_pkg; commanded by trb_ctrl.
module trb_datapath
    import trb_pkg::*;
#(
    parameter int LOG_DEPTH  = 10,
    parameter int DATA_WIDTH = 32,
    parameter int OWNER_BITS = 5
)
(
    input  logic                  clk,
    input  logic                  rst_n,
    // configuration
    input  logic                  cfg_we,
    input  logic [CFG_IDX_W-1:0]  cfg_index,
    input  logic [CFG_DATA_W-1:0] cfg_data,
    // input item
    input  logic [2:0]            mode,
    input  logic [DATA_WIDTH-1:0] rec_data,
    input  logic [OWNER_BITS-1:0] rec_owner,
    input  logic                  restart,
    // result
    output logic                  out_valid,
    input  logic                  out_stall,
    output logic                  ok,
    output logic [LOG_DEPTH-1:0]  slot,
    output logic [DATA_WIDTH-1:0] out_data,
    output logic [OWNER_BITS-1:0] out_owner,
    output logic                  found,
    output logic                  overflowed,
    output logic [LOG_DEPTH:0]    entry_count,
    output logic [15:0]           blocked_total,
    output logic                  locked,
    // control
    input  trb_cmd_t              cmd,
    output trb_status_t           st
);

    localparam int DEPTH  = 1 << LOG_DEPTH;
    localparam int WORD_W = 1 + OWNER_BITS + DATA_WIDTH;

    typedef struct packed {
        logic                  ok;
        logic [LOG_DEPTH-1:0]  slot;
        logic [DATA_WIDTH-1:0] data;
        logic [OWNER_BITS-1:0] owner;
        logic                  found;
        logic                  ovf;
        logic [LOG_DEPTH:0]    count;
        logic [15:0]           blocked;
        logic                  locked;
    } res_t;

    // Configuration registers
    logic        wrap_en_reg;
    logic [3:0]  size_log2_reg;
    logic [31:0] owner_mask_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wrap_en_reg    <= 1'b0;
            size_log2_reg  <= SIZE_LOG2_RESET;
            owner_mask_reg <= OWNER_MASK_RESET;
        end
        else if (cfg_we)
        begin
            unique case (cfg_index)
                CFG_WRAP_ENABLE:
                begin
                    wrap_en_reg <= cfg_data[0];
                end
                CFG_SIZE_LOG2:
                begin
                    size_log2_reg <= cfg_data[3:0];
                end
                CFG_OWNER_MASK:
                begin
                    owner_mask_reg <= cfg_data;
                end
                default:
                begin
                end
            endcase
        end
    end

    // Trace state
    logic                 ovf_reg,  ovf_next;
    logic                 done_reg, done_next;
    logic [LOG_DEPTH-1:0] wp_reg,   wp_next;
    logic [LOG_DEPTH-1:0] cur_reg,  cur_next;
    logic [LOG_DEPTH-1:0] idx_reg,  idx_next;
    logic [LOG_DEPTH-1:0] clr_reg,  clr_next;
    logic [7:0]           lock_reg, lock_next;
    logic [15:0]          blk_reg,  blk_next;

    // Store: valid, owner, data per slot
    logic [WORD_W-1:0]    mem_reg [DEPTH];
    logic [WORD_W-1:0]    rd_word_reg;
    logic                 mem_we;
    logic [LOG_DEPTH-1:0] mem_wa;
    logic [WORD_W-1:0]    mem_wd;
    logic                 rd_en;
    logic [LOG_DEPTH-1:0] rd_addr;

    // Active size
    logic [4:0]           n_eff;
    logic [LOG_DEPTH:0]   size_val;
    logic [LOG_DEPTH-1:0] smask;
    logic [LOG_DEPTH-1:0] wp;
    logic [LOG_DEPTH-1:0] last;

    always_comb
    begin
        if (size_log2_reg < SIZE_LOG2_MIN)
        begin
            n_eff = 5'(SIZE_LOG2_MIN);
        end
        else if (5'(size_log2_reg) > 5'(LOG_DEPTH))
        begin
            n_eff = 5'(LOG_DEPTH);
        end
        else
        begin
            n_eff = 5'(size_log2_reg);
        end
    end

    assign size_val = (LOG_DEPTH+1)'(1) << n_eff;
    assign smask    = LOG_DEPTH'(size_val - (LOG_DEPTH+1)'(1));
    assign wp       = wp_reg & smask;
    assign last     = (wp - LOG_DEPTH'(1)) & smask;

    // Read start point for a new read item
    logic                 any_rec;
    logic                 go;
    logic [LOG_DEPTH-1:0] start_idx;
    logic [LOG_DEPTH-1:0] cur_m;

    always_comb
    begin
        any_rec   = ovf_reg || (wp != '0);
        cur_m     = cur_reg & smask;
        go        = 1'b1;
        start_idx = '0;
        if (restart || done_reg)
        begin
            start_idx = ovf_reg ? wp : '0;
        end
        else if (cur_m == last)
        begin
            go = 1'b0;
        end
        else
        begin
            start_idx = (cur_m + LOG_DEPTH'(1)) & smask;
        end
    end

    // Scan check on the registered store word
    logic                  rd_valid;
    logic [OWNER_BITS-1:0] rd_owner;
    logic [DATA_WIDTH-1:0] rd_data;
    logic [5:0]            own6;
    logic                  hit;

    assign rd_valid = rd_word_reg[WORD_W-1];
    assign rd_owner = rd_word_reg[DATA_WIDTH +: OWNER_BITS];
    assign rd_data  = rd_word_reg[DATA_WIDTH-1:0];
    assign own6     = 6'(rd_owner);
    assign hit      = rd_valid && (own6 < 6'd32) && owner_mask_reg[own6[4:0]];

    // Status to controller
    assign st.rd_scan   = (mode == MODE_READ) && any_rec && go;
    assign st.is_clear  = (mode == MODE_CLEAR);
    assign st.scan_hit  = hit;
    assign st.scan_last = (idx_reg == last);
    assign st.clr_last  = (clr_reg == {LOG_DEPTH{1'b1}});

    // Item execution
    logic ok_i;
    logic [LOG_DEPTH-1:0] slot_i;
    logic push;

    always_comb
    begin
        wp_next   = wp_reg;
        ovf_next  = ovf_reg;
        lock_next = lock_reg;
        blk_next  = blk_reg;
        cur_next  = cur_reg;
        done_next = done_reg;
        idx_next  = idx_reg;
        clr_next  = clr_reg;
        ok_i      = 1'b1;
        slot_i    = '0;
        mem_we    = 1'b0;
        mem_wa    = '0;
        mem_wd    = '0;
        rd_en     = 1'b0;
        rd_addr   = start_idx;
        push      = 1'b0;

        if (cmd.accept)
        begin
            push = 1'b1;
            unique case (mode)
                MODE_INSERT:
                begin
                    if (lock_reg != '0)
                    begin
                        ok_i = 1'b0;
                        if (blk_reg != BLOCKED_MAX)
                        begin
                            blk_next = blk_reg + 16'd1;
                        end
                    end
                    else if (ovf_reg && !wrap_en_reg)
                    begin
                        ok_i = 1'b0;
                    end
                    else
                    begin
                        slot_i  = wp;
                        mem_we  = 1'b1;
                        mem_wa  = wp;
                        mem_wd  = {1'b1, rec_owner, rec_data};
                        wp_next = (wp + LOG_DEPTH'(1)) & smask;
                        if (wp == smask)
                        begin
                            ovf_next = 1'b1;
                        end
                    end
                end
                MODE_LOCK:
                begin
                    if (lock_reg != LOCK_MAX)
                    begin
                        lock_next = lock_reg + 8'd1;
                    end
                end
                MODE_UNLOCK:
                begin
                    if (lock_reg != '0)
                    begin
                        lock_next = lock_reg - 8'd1;
                    end
                    else
                    begin
                        ok_i = 1'b0;
                    end
                end
                MODE_READ:
                begin
                    if (st.rd_scan)
                    begin
                        push     = 1'b0;
                        rd_en    = 1'b1;
                        idx_next = start_idx;
                    end
                    else
                    begin
                        cur_next  = '0;
                        done_next = 1'b1;
                    end
                end
                MODE_CLEAR:
                begin
                    wp_next   = '0;
                    ovf_next  = 1'b0;
                    lock_next = '0;
                    blk_next  = '0;
                    cur_next  = '0;
                    done_next = 1'b1;
                    clr_next  = '0;
                end
                default:
                begin
                end
            endcase
        end

        // Scan: step on a miss, finish on a hit or the newest slot
        if (cmd.scan_next)
        begin
            idx_next = (idx_reg + LOG_DEPTH'(1)) & smask;
            rd_en    = 1'b1;
            rd_addr  = idx_next;
        end
        if (cmd.scan_done)
        begin
            push = 1'b1;
            if (hit)
            begin
                cur_next  = idx_reg;
                done_next = 1'b0;
            end
            else
            begin
                cur_next  = '0;
                done_next = 1'b1;
            end
        end

        // Clearing pass over the whole store
        if (cmd.clr_step)
        begin
            mem_we   = 1'b1;
            mem_wa   = clr_reg;
            mem_wd   = '0;
            clr_next = clr_reg + LOG_DEPTH'(1);
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wp_reg   <= '0;
            ovf_reg  <= 1'b0;
            lock_reg <= '0;
            blk_reg  <= '0;
            cur_reg  <= '0;
            done_reg <= 1'b1;
            idx_reg  <= '0;
            clr_reg  <= '0;
        end
        else
        begin
            wp_reg   <= wp_next;
            ovf_reg  <= ovf_next;
            lock_reg <= lock_next;
            blk_reg  <= blk_next;
            cur_reg  <= cur_next;
            done_reg <= done_next;
            idx_reg  <= idx_next;
            clr_reg  <= clr_next;
        end
    end

    // Store write and registered read
    always_ff @(posedge clk)
    begin
        if (mem_we)
        begin
            mem_reg[mem_wa] <= mem_wd;
        end
        if (rd_en)
        begin
            rd_word_reg <= mem_reg[rd_addr];
        end
    end

    // Result beat, built from post-item state
    res_t res;

    always_comb
    begin
        res.ok      = cmd.scan_done ? 1'b1 : ok_i;
        res.slot    = (cmd.scan_done && hit) ? idx_reg : slot_i;
        res.data    = (cmd.scan_done && hit) ? rd_data : '0;
        res.owner   = (cmd.scan_done && hit) ? rd_owner : '0;
        res.found   = cmd.scan_done && hit;
        res.ovf     = ovf_next;
        res.count   = ovf_next ? size_val : {1'b0, wp_next & smask};
        res.blocked = blk_next;
        res.locked  = (lock_next != '0);
    end

    // Output register plus skid
    res_t out_reg, out_next;
    res_t skid_reg, skid_next;
    logic out_valid_reg, out_valid_next;
    logic skid_valid_reg, skid_valid_next;
    logic out_take;

    assign out_take = out_valid_reg && !out_stall;

    always_comb
    begin
        out_next        = out_reg;
        skid_next       = skid_reg;
        out_valid_next  = out_valid_reg;
        skid_valid_next = skid_valid_reg;
        priority if (out_take && skid_valid_reg)
        begin
            out_next = skid_reg;
            if (push)
            begin
                skid_next = res;
            end
            else
            begin
                skid_valid_next = 1'b0;
            end
        end
        else if (out_take || !out_valid_reg)
        begin
            out_valid_next = push;
            if (push)
            begin
                out_next = res;
            end
        end
        else if (push)
        begin
            skid_valid_next = 1'b1;
            skid_next       = res;
        end
        else
        begin
            // held beat, nothing new: both stages keep their contents
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg  <= 1'b0;
            skid_valid_reg <= 1'b0;
        end
        else
        begin
            out_valid_reg  <= out_valid_next;
            skid_valid_reg <= skid_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        out_reg  <= out_next;
        skid_reg <= skid_next;
    end

    assign st.skid_full  = skid_valid_reg;
    assign out_valid     = out_valid_reg;
    assign ok            = out_reg.ok;
    assign slot          = out_reg.slot;
    assign out_data      = out_reg.data;
    assign out_owner     = out_reg.owner;
    assign found         = out_reg.found;
    assign overflowed    = out_reg.ovf;
    assign entry_count   = out_reg.count;
    assign blocked_total = out_reg.blocked;
    assign locked        = out_reg.locked;

    // Skid only fills behind a held output beat
    a_skid_order: assert property (@(posedge clk) disable iff (!rst_n)
        skid_valid_reg |-> out_valid_reg)
        else $error("trb_datapath: skid holds a beat with output empty");

    // A result never lands on a full skid
    a_no_drop: assert property (@(posedge clk) disable iff (!rst_n)
        (push && out_valid_reg && !out_take) |-> !skid_valid_reg)
        else $error("trb_datapath: result beat dropped");

    // Clear leaves pointers, flag, lock and count at zero
    a_clear_state: assert property (@(posedge clk) disable iff (!rst_n)
        (cmd.accept && mode == MODE_CLEAR) |=>
        (wp_reg == '0 && !ovf_reg && lock_reg == '0 && blk_reg == '0 && done_reg))
        else $error("trb_datapath: clear left state behind");

    // A hit moves the cursor onto the found slot
    a_hit_cursor: assert property (@(posedge clk) disable iff (!rst_n)
        (cmd.scan_done && hit) |=> (!done_reg && cur_reg == $past(idx_reg)))
        else $error("trb_datapath: cursor not updated on read hit");

endmodule
